// ----- rtl/spli_pkg.sv -----
// Shared types, field widths, command codes and the semitone table
// for the sampler voice. No dependencies.
package spli_pkg;

  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int SMP_W       = 16;
  localparam int NOTE_W      = 7;
  localparam int GAIN_W      = 17;
  localparam int LEN_W       = 17;
  localparam int RATE_W      = 24;
  localparam int SEMI_W      = 17;
  localparam int SHAMT_W     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 40;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_NOTE_ON = 2'd1,
    FUNC_STOP    = 2'd2,
    FUNC_RENDER  = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEREO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NOTE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO    = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]  sample_length;
    logic              loop_enable;
    logic              source_stereo;
    logic              output_stereo;
    logic [NOTE_W-1:0] root_note;
    logic [RATE_W-1:0] rate_ratio;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_length: 17'd0,
    loop_enable:   1'b0,
    source_stereo: 1'b1,
    output_stereo: 1'b1,
    root_note:     7'd60,
    rate_ratio:    24'd65536
  };

  typedef struct packed {
    func_t              func;
    logic [ADDR_W-1:0]  addr;
    logic [SMP_W-1:0]   write_left;
    logic [SMP_W-1:0]   write_right;
    logic [GAIN_W-1:0]  env_gain;
    logic [SEMI_W-1:0]  semi_gain;
    logic [SHAMT_W-1:0] step_shift;
  } cmd_t;

  // 2^(s/12) in 1.16
  function automatic logic [SEMI_W-1:0] semitone_q16(input logic [3:0] s);
    logic [SEMI_W-1:0] v;
    case (s)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd69433;
      4'd2:    v = 17'd73562;
      4'd3:    v = 17'd77936;
      4'd4:    v = 17'd82570;
      4'd5:    v = 17'd87480;
      4'd6:    v = 17'd92682;
      4'd7:    v = 17'd98193;
      4'd8:    v = 17'd104032;
      4'd9:    v = 17'd110218;
      4'd10:   v = 17'd116772;
      4'd11:   v = 17'd123715;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/spli_front.sv -----
// Input stage: takes beats, splits the note offset into octave shift and
// semitone gain, and holds one classified command. Depends on spli_pkg.
module spli_front import spli_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [FUNC_W-1:0]    in_tuser,
  input  cfg_t                 cfg,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_t                 push_cmd
);

  localparam int SH_BASE = 45 - FRACTION_BITS;

  logic        slot_v_r;
  cmd_t        slot_r;
  cmd_t        cmd_nxt;
  logic [8:0]  note_ofs;
  logic [16:0] quo_prod;
  logic [4:0]  octq;
  logic [8:0]  rem;

  // octave index by reciprocal multiply: floor(d * 171 / 2048) == floor(d / 12) for d < 260
  always_comb begin
    note_ofs = {2'b00, in_tdata[54:48]} - {2'b00, cfg.root_note} + 9'd132;
    quo_prod = 17'(note_ofs) * 17'd171;
    octq     = quo_prod[15:11];
    rem      = note_ofs - (9'(octq) * 9'd12);

    cmd_nxt.func        = func_t'(in_tuser);
    cmd_nxt.addr        = in_tdata[15:0];
    cmd_nxt.write_left  = in_tdata[31:16];
    cmd_nxt.write_right = in_tdata[47:32];
    cmd_nxt.env_gain    = in_tdata[71:55];
    cmd_nxt.semi_gain   = semitone_q16(rem[3:0]);
    cmd_nxt.step_shift  = SHAMT_W'(SH_BASE) - SHAMT_W'(octq);
  end

  assign in_tready  = !slot_v_r || push_ready;
  assign push_valid = slot_v_r;
  assign push_cmd   = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else if (in_tready) begin
      slot_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      slot_r <= cmd_nxt;
    end
  end

endmodule

// ----- rtl/spli_queue.sv -----
// Short command queue between the input stage and the voice engine.
// Depends on spli_pkg.
module spli_queue import spli_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;

  assign push_ready = cnt_r != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slots_r[rp_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({do_push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/spli_back.sv -----
// Voice engine: sample memory, position and step state, note-on step
// calculation and the interpolate / gain / round pipeline. Depends on spli_pkg.
module spli_back import spli_pkg::*; #(
  parameter int SAMPLE_DEPTH  = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int FB      = FRACTION_BITS;
  localparam int STEP_W  = 8 + FB;
  localparam int POS_W   = LEN_W + FB;
  localparam int IDX_W   = LEN_W;
  localparam int MEM_AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int XW      = ((MEM_AW > IDX_W) ? MEM_AW : IDX_W) + 1;
  localparam int PROD_W  = RATE_W + SEMI_W;
  localparam int EXT_W   = PROD_W + 3;
  localparam int INT_W   = FB + SMP_W;
  localparam int FULL_W  = SMP_W + FB + 2;
  localparam int MIX_W   = INT_W + 1;
  localparam int GN_W    = MIX_W + GAIN_W + 1;
  localparam int RS      = FB + SMP_W;
  localparam int SAT_W   = GN_W - RS;
  localparam int PAD_W   = OUT_DATA_W - 2 * SMP_W - 2;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [FB:0]       FRAC_ONE = {1'b1, {FB{1'b0}}};
  localparam logic [GN_W-1:0]   HALF_S   = GN_W'(1) << (RS - 1);
  localparam logic [GN_W-1:0]   HALF_M   = GN_W'(1) << RS;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_N_MUL    = 7'b0000010,
    ST_N_STEP   = 7'b0000100,
    ST_R_WEIGHT = 7'b0001000,
    ST_R_MIX    = 7'b0010000,
    ST_R_GAIN   = 7'b0100000,
    ST_R_SCALE  = 7'b1000000
  } state_t;

  function automatic logic [SMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [SMP_W-1:0] r;
    if (v > 32767) begin
      r = 16'h7FFF;
    end else if (v < -32768) begin
      r = 16'h8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [2*SMP_W-1:0] mem [SAMPLE_DEPTH];
  logic [2*SMP_W-1:0] rd0_r, rd1_r;
  logic               z0_r, z1_r;
  logic [FB-1:0]      frac_r;

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  sum_r;
  logic [STEP_W-1:0] step_r;
  logic              playing_r;
  logic              ended_r;
  cmd_t              cur_r;
  logic [PROD_W-1:0] prod_r;

  logic signed [INT_W-1:0] pal_r, pbl_r, par_r, pbr_r;
  logic signed [INT_W-1:0] l_r, r_r;
  logic signed [MIX_W-1:0] m_r;
  logic signed [GN_W-1:0]  gl_r, gr_r;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [XW-1:0]     idx0_x, idx1_x, wa_x;
  logic              z0, z1, wa_ok, mem_we;
  logic [MEM_AW-1:0] ra0, ra1, wa;

  logic signed [SMP_W-1:0]  a_l, b_l, a_r, b_r;
  logic signed [FB+1:0]     w0, w1;
  logic signed [FULL_W-1:0] pal_full, pbl_full, par_full, pbr_full;

  logic signed [INT_W-1:0] lsum, rsum, rsel;
  logic signed [MIX_W-1:0] msum, gsel;
  logic signed [GN_W-1:0]  gl_full, gr_full;
  logic signed [GN_W-1:0]  lt, rt, mt;
  logic signed [SAT_W-1:0] lq, rq, mq;

  logic [EXT_W-1:0]  ext3, shifted, rounded;
  logic [STEP_W-1:0] step_new;

  logic             res_valid, res_active;
  logic [SMP_W-1:0] res_left, res_right;

  // memory addressing
  always_comb begin
    idx0_x = XW'(pos_r[POS_W-1:FB]);
    idx1_x = idx0_x + XW'(1);
    z0     = (idx0_x >= XW'(cfg.sample_length)) || (idx0_x >= XW'(SAMPLE_DEPTH));
    z1     = (idx1_x >= XW'(cfg.sample_length)) || (idx1_x >= XW'(SAMPLE_DEPTH));
    ra0    = idx0_x[MEM_AW-1:0];
    ra1    = idx1_x[MEM_AW-1:0];
    wa_x   = XW'(q_cmd.addr);
    wa_ok  = wa_x < XW'(SAMPLE_DEPTH);
    wa     = wa_x[MEM_AW-1:0];
    mem_we = q_pop && (q_cmd.func == FUNC_WRITE) && wa_ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= {q_cmd.write_right, q_cmd.write_left};
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // note-on step: round and saturate rate * semitone, shifted by octave
  always_comb begin
    ext3     = {prod_r, 3'b000};
    shifted  = ext3 >> cur_r.step_shift;
    rounded  = {1'b0, shifted[EXT_W-1:1]} + EXT_W'(shifted[0]);
    step_new = (rounded > EXT_W'(STEP_MAX)) ? STEP_MAX : rounded[STEP_W-1:0];
  end

  // interpolation datapath
  always_comb begin
    a_l = z0_r ? '0 : $signed(rd0_r[SMP_W-1:0]);
    b_l = z1_r ? '0 : $signed(rd1_r[SMP_W-1:0]);
    a_r = z0_r ? '0 : $signed(rd0_r[2*SMP_W-1:SMP_W]);
    b_r = z1_r ? '0 : $signed(rd1_r[2*SMP_W-1:SMP_W]);
    w0  = $signed({1'b0, FRAC_ONE - {1'b0, frac_r}});
    w1  = $signed({2'b00, frac_r});
    pal_full = a_l * w0;
    pbl_full = b_l * w1;
    par_full = a_r * w0;
    pbr_full = b_r * w1;

    lsum = pal_r + pbl_r;
    rsum = par_r + pbr_r;
    rsel = cfg.source_stereo ? rsum : lsum;
    msum = {lsum[INT_W-1], lsum} + {rsel[INT_W-1], rsel};

    gsel    = cfg.output_stereo ? {r_r[INT_W-1], r_r} : m_r;
    gl_full = {{(GN_W-INT_W){l_r[INT_W-1]}}, l_r} * $signed({1'b0, cur_r.env_gain});
    gr_full = {{(GN_W-MIX_W){gsel[MIX_W-1]}}, gsel} * $signed({1'b0, cur_r.env_gain});

    lt = gl_r + $signed(HALF_S);
    rt = gr_r + $signed(HALF_S);
    mt = gr_r + $signed(HALF_M);
    lq = lt[GN_W-1:RS];
    rq = rt[GN_W-1:RS];
    mq = {mt[GN_W-1], mt[GN_W-1:RS+1]};
  end

  // sequencer and result selection
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    res_left   = '0;
    res_right  = '0;
    res_active = playing_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && (!out_v_r || out_tready)) begin
          q_pop = 1'b1;
          case (q_cmd.func)
            FUNC_WRITE: begin
              res_valid = 1'b1;
            end
            FUNC_NOTE_ON: begin
              state_nxt = ST_N_MUL;
            end
            FUNC_STOP: begin
              res_valid  = 1'b1;
              res_active = 1'b0;
            end
            FUNC_RENDER: begin
              if (playing_r) begin
                state_nxt = ST_R_WEIGHT;
              end else begin
                res_valid  = 1'b1;
                res_active = 1'b0;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_N_MUL: begin
        state_nxt = ST_N_STEP;
      end
      ST_N_STEP: begin
        res_valid  = 1'b1;
        res_active = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_R_WEIGHT: begin
        state_nxt = ST_R_MIX;
      end
      ST_R_MIX: begin
        state_nxt = ST_R_GAIN;
      end
      ST_R_GAIN: begin
        state_nxt = ST_R_SCALE;
      end
      ST_R_SCALE: begin
        res_valid = 1'b1;
        if (cfg.output_stereo) begin
          res_left  = sat16(lq);
          res_right = sat16(rq);
        end else begin
          res_left = sat16(mq);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      step_r    <= '0;
      playing_r <= 1'b0;
      ended_r   <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_valid) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (q_pop && (q_cmd.func == FUNC_STOP)) begin
        playing_r <= 1'b0;
      end
      if (q_pop && (q_cmd.func == FUNC_RENDER)) begin
        ended_r <= 1'b0;
      end
      if (state_r == ST_N_STEP) begin
        pos_r     <= '0;
        step_r    <= step_new;
        playing_r <= 1'b1;
      end
      if (state_r == ST_R_WEIGHT) begin
        if (sum_r > {cfg.sample_length, {FB{1'b0}}}) begin
          if (cfg.loop_enable) begin
            pos_r <= '0;
          end else begin
            pos_r     <= sum_r;
            playing_r <= 1'b0;
            ended_r   <= 1'b1;
          end
        end else begin
          pos_r <= sum_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    z0_r   <= z0;
    z1_r   <= z1;
    frac_r <= pos_r[FB-1:0];
    sum_r  <= pos_r + POS_W'(step_r);
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    prod_r <= cur_r.semi_gain * PROD_W'(cfg.rate_ratio);
    pal_r  <= pal_full[INT_W-1:0];
    pbl_r  <= pbl_full[INT_W-1:0];
    par_r  <= par_full[INT_W-1:0];
    pbr_r  <= pbr_full[INT_W-1:0];
    l_r    <= lsum;
    r_r    <= rsel;
    m_r    <= msum;
    gl_r   <= gl_full;
    gr_r   <= gr_full;
    if (res_valid) begin
      out_data_r <= {{PAD_W{1'b0}}, (state_r == ST_R_SCALE) && ended_r, res_active,
                     res_right, res_left};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/sample_player_linear_interp.sv -----
// Top level of the sampler voice: configuration registers, input stage,
// command queue and voice engine. Depends on spli_pkg, spli_front,
// spli_queue and spli_back.
//
//   port group | dir | payload
//   in_*       | in  | tuser: func; tdata: addr, write_left, write_right, note, env_gain
//   out_*      | out | tdata: out_left, out_right, voice_active, voice_ended
//   cfg_*      | in  | cfg_index selects register, cfg_wdata value, cfg_wen strobe
//
// The voice engine runs one command at a time: a sample write, a hard stop or
// a tick on an idle voice is answered from the idle state, a note-on steps
// through step multiply and shift, a tick on a playing voice through memory
// read, weights, mix and gain to rounding. The input register and a two-deep
// queue keep taking beats, until full, while the output register holds an
// untaken result. Reset is synchronous; the sample memory is not cleared.
module sample_player_linear_interp import spli_pkg::*; #(
  parameter int SAMPLE_DEPTH  = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // addr, write_left, write_right, note, env_gain
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_left, out_right, voice_active, voice_ended
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic push_valid, push_ready, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_SAMPLE_LENGTH: cfg_r.sample_length <= cfg_wdata[LEN_W-1:0];
        CFG_LOOP_ENABLE:   cfg_r.loop_enable   <= cfg_wdata[0];
        CFG_SOURCE_STEREO: cfg_r.source_stereo <= cfg_wdata[0];
        CFG_OUTPUT_STEREO: cfg_r.output_stereo <= cfg_wdata[0];
        CFG_ROOT_NOTE:     cfg_r.root_note     <= cfg_wdata[NOTE_W-1:0];
        CFG_RATE_RATIO:    cfg_r.rate_ratio    <= cfg_wdata[RATE_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  spli_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  spli_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  spli_back #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
